// ===== rtl/rbst_pkg.sv =====
// Shared types and constants for the ray/box slab test block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rbst_pkg;
    localparam int FieldWidth = 32;
    localparam int FracBits   = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    // One queue entry: a classified item waiting for the back end.
    typedef struct packed {
        logic                    is_test;
        logic [FieldWidth-1:0]   a_x;
        logic [FieldWidth-1:0]   a_y;
        logic [FieldWidth-1:0]   a_z;
        logic [FieldWidth-1:0]   b_x;
        logic [FieldWidth-1:0]   b_y;
        logic [FieldWidth-1:0]   b_z;
        logic [FieldWidth-1:0]   limit_in;
    } item_t;
endpackage

// ===== rtl/rbst_div.sv =====
// Iterative saturating signed divider, one quotient bit per cycle.
// Depends on rbst_pkg for the fraction width.
`timescale 1ns / 1ps
module rbst_div #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [CW:0]          num,    // exact difference, CW+1 bits signed
    input  logic [CW-1:0]        den,
    output logic                 done,
    output logic [CW-1:0]        quo
);
    localparam int NW    = CW + 1;            // numerator magnitude width
    localparam int STEPS = NW + rbst_pkg::FracBits;
    localparam int CNTW  = $clog2(STEPS + 1);
    localparam int QW    = CW + 1;            // quotient bits kept before saturation

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [STEPS-1:0] sh_reg, sh_next;        // numerator bits, shifted out MSB first
    logic [CW:0]     rem_reg, rem_next;
    logic [CW-1:0]   dmag_reg, dmag_next;
    logic [QW-1:0]   q_reg, q_next;
    logic            ovf_reg, ovf_next;
    logic            neg_reg, neg_next;
    logic            zero_reg, zero_next;
    logic            nneg_reg, nneg_next;
    logic [CW-1:0]   quo_reg, quo_next;

    logic [NW-1:0]   nmag;
    logic [CW+1:0]   trial;
    logic            qb;
    logic [CW+1:0]   rsh;
    logic [QW-1:0]   maxpos;

    assign nmag   = num[CW] ? NW'(-num) : NW'(num);
    assign maxpos = QW'({1'b0, {(CW-1){1'b1}}});
    assign rsh    = {rem_reg, sh_reg[STEPS-1]};
    assign trial  = rsh - {2'b00, dmag_reg};
    assign qb     = !trial[CW+1];

    // Shift-subtract iteration and final saturation.
    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        nneg_next = nneg_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = {nmag, {rbst_pkg::FracBits{1'b0}}};
            rem_next  = '0;
            dmag_next = den[CW-1] ? -den : den;
            q_next    = '0;
            ovf_next  = 1'b0;
            nneg_next = num[CW] && (num != '0);
            neg_next  = num[CW] != den[CW-1];
            zero_next = (den == '0);
        end else if (busy_reg) begin
            if (cnt_reg == CNTW'(STEPS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    quo_next = nneg_reg ? {1'b1, {(CW-1){1'b0}}} : maxpos[CW-1:0];
                else if (!neg_reg)
                    quo_next = (ovf_reg || q_reg > maxpos) ? maxpos[CW-1:0]
                                                           : q_reg[CW-1:0];
                else
                    quo_next = (ovf_reg || q_reg > maxpos + QW'(1))
                             ? {1'b1, {(CW-1){1'b0}}} : CW'(-q_reg);
            end else begin
                cnt_next = cnt_reg + CNTW'(1);
                sh_next  = sh_reg << 1;
                rem_next = qb ? trial[CW:0] : rsh[CW:0];
                if (q_reg[QW-1])
                    ovf_next = 1'b1;
                q_next = {q_reg[QW-2:0], qb};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        nneg_reg <= nneg_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/rbst_front.sv =====
// Front end: accepts stream transactions, decodes the opcode, and queues items.
// Depends on rbst_pkg for the item type.
`timescale 1ns / 1ps
module rbst_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [231:0]        s_tdata,
    output logic                q_valid,
    input  logic                q_pop,
    output rbst_pkg::item_t     q_item
);
    localparam int FW = rbst_pkg::FieldWidth;

    rbst_pkg::item_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic       push;
    rbst_pkg::item_t in_item;

    // Unpack the transaction and classify it.
    always_comb begin
        in_item.is_test  = (rbst_pkg::op_t'(s_tdata[0]) == rbst_pkg::OP_TEST);
        in_item.a_x      = s_tdata[1 + 0*FW +: FW];
        in_item.a_y      = s_tdata[1 + 1*FW +: FW];
        in_item.a_z      = s_tdata[1 + 2*FW +: FW];
        in_item.b_x      = s_tdata[1 + 3*FW +: FW];
        in_item.b_y      = s_tdata[1 + 4*FW +: FW];
        in_item.b_z      = s_tdata[1 + 5*FW +: FW];
        in_item.limit_in = s_tdata[1 + 6*FW +: FW];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    // Two-entry queue pointers.
    always_comb begin
        wp_next  = push  ? !wp_reg : wp_reg;
        rp_next  = q_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
        if (push)
            mem_reg[wp_reg] <= in_item;
    end
endmodule

// ===== rtl/rbst_back.sv =====
// Back end: holds the ray, runs six dividers per box and folds the intervals.
// Depends on rbst_pkg and rbst_div.
`timescale 1ns / 1ps
module rbst_back #(
    parameter int CW = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  rbst_pkg::item_t     q_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                hit
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FOLD, ST_OUT} state_t;

    state_t state_reg;
    logic [CW-1:0] org_reg [3];
    logic [CW-1:0] dir_reg [3];
    logic [CW-1:0] lim_reg;
    logic [CW-1:0] qa_reg [3];
    logic [CW-1:0] qb_reg [3];
    logic          hit_reg;
    logic          start;
    logic [5:0]    dn;
    logic [CW-1:0] qa [3];
    logic [CW-1:0] qb [3];
    logic [CW-1:0] lo [3];
    logic [CW-1:0] hi [3];
    logic [CW-1:0] tmin1, tmax1, tmin2;
    logic          miss1, miss2, hit_c;
    logic [CW-1:0] ca [3];
    logic [CW-1:0] cb [3];

    // Fields are signed; narrowing wraps and widening sign-extends.
    assign ca[0] = CW'($signed(q_item.a_x));
    assign ca[1] = CW'($signed(q_item.a_y));
    assign ca[2] = CW'($signed(q_item.a_z));
    assign cb[0] = CW'($signed(q_item.b_x));
    assign cb[1] = CW'($signed(q_item.b_y));
    assign cb[2] = CW'($signed(q_item.b_z));

    assign start = (state_reg == ST_IDLE) && q_valid && q_item.is_test;
    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Two dividers per axis, entry and exit planes.
    for (genvar g = 0; g < 3; g++) begin : g_axis
        rbst_div #(.CW(CW)) u_div_a (
            .aclk(aclk), .aresetn(aresetn), .start(start),
            .num({ca[g][CW-1], ca[g]} - {org_reg[g][CW-1], org_reg[g]}),
            .den(dir_reg[g]), .done(dn[2*g]), .quo(qa[g]));
        rbst_div #(.CW(CW)) u_div_b (
            .aclk(aclk), .aresetn(aresetn), .start(start),
            .num({cb[g][CW-1], cb[g]} - {org_reg[g][CW-1], org_reg[g]}),
            .den(dir_reg[g]), .done(dn[2*g+1]), .quo(qb[g]));
        assign lo[g] = ($signed(qa_reg[g]) > $signed(qb_reg[g])) ? qb_reg[g] : qa_reg[g];
        assign hi[g] = ($signed(qa_reg[g]) > $signed(qb_reg[g])) ? qa_reg[g] : qb_reg[g];
    end

    // Interval intersection over the three axes.
    always_comb begin
        miss1 = ($signed(lo[0]) > $signed(hi[1])) || ($signed(lo[1]) > $signed(hi[0]));
        tmin1 = ($signed(lo[1]) > $signed(lo[0])) ? lo[1] : lo[0];
        tmax1 = ($signed(hi[0]) > $signed(hi[1])) ? hi[1] : hi[0];
        miss2 = ($signed(tmin1) > $signed(hi[2])) || ($signed(lo[2]) > $signed(tmax1));
        tmin2 = ($signed(lo[2]) > $signed(tmin1)) ? lo[2] : tmin1;
        hit_c = !miss1 && !miss2 && !($signed(tmin2) > $signed(lim_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++) begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            lim_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_item.is_test) begin
                        state_reg <= ST_DIV;
                    end else if (q_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            org_reg[i] <= ca[i];
                            dir_reg[i] <= cb[i];
                        end
                        lim_reg <= CW'($signed(q_item.limit_in));
                    end
                end
                ST_DIV: begin
                    if (&dn) begin
                        for (int i = 0; i < 3; i++) begin
                            qa_reg[i] <= qa[i];
                            qb_reg[i] <= qb[i];
                        end
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    hit_reg   <= hit_c;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign hit      = hit_reg;
endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Ray against axis-aligned box slab test, top level.
// A box test passes through the queue, then the bit-serial dividers (COORD_WIDTH + 17 steps,
// six side by side), then the fold and output states before its result is raised.
// The back end takes no new test until the last result is taken; loads produce no result and
// drain one per cycle while the back end is idle; a two-entry queue buffers input.
// Reset (aresetn low, synchronous) clears the ray to zero origin, direction and limit.
`timescale 1ns / 1ps
module ray_box_slab_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [231:0]  s_tdata,   // opcode, a_x, a_y, a_z, b_x, b_y, b_z, limit_in
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata    // hit, then zero padding
);
    logic            q_valid, q_pop, hit;
    rbst_pkg::item_t q_item;

    rbst_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

    rbst_back #(.CW(COORD_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready), .hit(hit));

    assign m_tdata = {7'b0, hit};

    // A result never appears out of reset.
    a_no_out_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    // A waiting result holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    // The queue never pops while a result waits.
    a_no_pop_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q_pop)
        else $error("queue popped during result");
endmodule
